// ===== sv/srb_pkg.sv =====
// Shared constants and types for the sample ring buffer.
`default_nettype none

package srb_pkg;

	localparam int DEPTH       = 16;
	localparam int SAMPLE_BITS = 32;
	localparam int PTR_W       = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CNT_W       = $clog2(DEPTH + 1);

	localparam int CMD_W    = 2;
	localparam int WORD_W   = 32;
	localparam int BACK_W   = 4;
	localparam int FILL_W   = 5;
	localparam int OVR_W    = 32;

	typedef logic [PTR_W-1:0]       ptr_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [SAMPLE_BITS-1:0] sample_t;

	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	localparam logic POLICY_DROP      = 1'b0;
	localparam logic POLICY_OVERWRITE = 1'b1;

endpackage

`default_nettype wire

// ===== sv/srb_if.sv =====
// Request and response channel interfaces for the sample ring buffer.
`default_nettype none

interface srb_req_if;
	import srb_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [WORD_W-1:0]   sample_in;
	logic [BACK_W-1:0]   back_index;

	modport source(output valid, cmd, sample_in, back_index, input ready);
	modport sink(input valid, cmd, sample_in, back_index, output ready);
endinterface

interface srb_rsp_if;
	import srb_pkg::*;
	logic                valid;
	logic                ready;
	logic                status;
	logic [WORD_W-1:0]   sample_out;
	logic [FILL_W-1:0]   fill_count;
	logic [OVR_W-1:0]    overrun_total;

	modport source(output valid, status, sample_out, fill_count, overrun_total, input ready);
	modport sink(input valid, status, sample_out, fill_count, overrun_total, output ready);
endinterface

`default_nettype wire

// ===== sv/srb_ram.sv =====
// Sample store: one write port, one read port, registered read data.
`default_nettype none

module srb_ram (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire srb_pkg::ptr_t   waddr,
	input  wire srb_pkg::sample_t wdata,
	input  wire logic            re,
	input  wire srb_pkg::ptr_t   raddr,
	output srb_pkg::sample_t     rdata
);
	import srb_pkg::*;

	sample_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the last read word while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/sample_ring_buffer_with_overrun_policy_unit.sv =====
// Sample ring buffer top level: pointer control, read stage and result register.
// Each accepted transaction passes the read stage, then the result register.
// Throughput: one transaction per cycle unless stalled; the single-port read of the
// sample store sits in one stage; pointers and counters update at acceptance.
// A stalled result register holds the read stage and thereby the request side.
// Reset (arst_n low) clears pointers, occupancy, overrun total and policy;
// the sample store is not cleared.
`default_nettype none

module sample_ring_buffer_with_overrun_policy_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	srb_req_if.sink   req,
	srb_rsp_if.source rsp
);
	import srb_pkg::*;

	function automatic ptr_t advance(input ptr_t pos);
		advance = (pos == PTR_W'(DEPTH - 1)) ? '0 : pos + 1'b1;
	endfunction

	logic             policy_q;
	ptr_t             wp_q, rp_q;
	cnt_t             occ_q;
	logic [OVR_W-1:0] ovr_q;

	ptr_t             wp_n, rp_n;
	cnt_t             occ_n;
	logic [OVR_W-1:0] ovr_n;
	logic             wr_c, rd_c, status_c;
	ptr_t             rd_addr_c;
	logic [PTR_W:0]   peek_sum;
	ptr_t             peek_pos;

	logic             pend_s1, status_s1, is_rd_s1;
	cnt_t             fill_s1;
	logic [OVR_W-1:0] ovr_s1;
	sample_t          rdata;

	logic             out_valid_q, status_q;
	logic [WORD_W-1:0] sample_out_q;
	logic [FILL_W-1:0] fill_q;
	logic [OVR_W-1:0] ovr_out_q;

	logic accept, s1_adv;

	assign s1_adv    = !out_valid_q || rsp.ready;
	assign req.ready = !pend_s1 || s1_adv;
	assign accept    = req.valid && req.ready;

	// newest-relative position: write pointer minus one minus offset, modulo depth
	always_comb begin
		peek_sum = (PTR_W+1)'(wp_q) + (PTR_W+1)'(DEPTH - 1) - (PTR_W+1)'(req.back_index);
		peek_pos = (peek_sum >= (PTR_W+1)'(DEPTH)) ? PTR_W'(peek_sum - (PTR_W+1)'(DEPTH))
		                                          : PTR_W'(peek_sum);
	end

	always_comb begin
		wp_n      = wp_q;
		rp_n      = rp_q;
		occ_n     = occ_q;
		ovr_n     = ovr_q;
		wr_c      = 1'b0;
		rd_c      = 1'b0;
		rd_addr_c = rp_q;
		status_c  = STATUS_FAIL;
		case (req.cmd)
			CMD_PUSH: begin
				if (occ_q == CNT_W'(DEPTH)) begin
					ovr_n = ovr_q + 1'b1;
					if (policy_q == POLICY_OVERWRITE) begin
						// drop oldest, store new; occupancy stays full
						rp_n     = advance(rp_q);
						wp_n     = advance(wp_q);
						wr_c     = 1'b1;
						status_c = STATUS_OK;
					end
				end else begin
					wp_n     = advance(wp_q);
					occ_n    = occ_q + 1'b1;
					wr_c     = 1'b1;
					status_c = STATUS_OK;
				end
			end
			CMD_POP: begin
				if (occ_q != '0) begin
					rd_c     = 1'b1;
					rp_n     = advance(rp_q);
					occ_n    = occ_q - 1'b1;
					status_c = STATUS_OK;
				end
			end
			CMD_PEEK: begin
				if (occ_q != '0 && 32'(req.back_index) < 32'(occ_q)) begin
					rd_c      = 1'b1;
					rd_addr_c = peek_pos;
					status_c  = STATUS_OK;
				end
			end
			default: begin
			end
		endcase
	end

	srb_ram u_ram (
		.clk   (clk),
		.we    (accept && wr_c),
		.waddr (wp_q),
		.wdata (SAMPLE_BITS'(req.sample_in)),
		.re    (accept && rd_c),
		.raddr (rd_addr_c),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_DROP;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			occ_q <= '0;
			ovr_q <= '0;
		end else if (accept) begin
			wp_q  <= wp_n;
			rp_q  <= rp_n;
			occ_q <= occ_n;
			ovr_q <= ovr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (accept) begin
			pend_s1 <= 1'b1;
		end else if (s1_adv) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_c;
			is_rd_s1  <= rd_c;
			fill_s1   <= occ_n;
			ovr_s1    <= ovr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1 && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1 && s1_adv) begin
			status_q     <= status_s1;
			sample_out_q <= is_rd_s1 ? WORD_W'(rdata) : '0;
			fill_q       <= FILL_W'(fill_s1);
			ovr_out_q    <= ovr_s1;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.sample_out    = sample_out_q;
	assign rsp.fill_count    = fill_q;
	assign rsp.overrun_total = ovr_out_q;

	// pointer gap must agree with occupancy unless the buffer is full
	ptr_t ptr_gap;
	assign ptr_gap = (wp_q >= rp_q) ? ptr_t'(wp_q - rp_q)
	                                : ptr_t'(PTR_W'(DEPTH) - rp_q + wp_q);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != CNT_W'(DEPTH)) |-> (CNT_W'(ptr_gap) == occ_q))
		else $error("pointer gap disagrees with occupancy");

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == CNT_W'(DEPTH)) |-> (wp_q == rp_q))
		else $error("full buffer with unequal pointers");

	a_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == CMD_PUSH && occ_q == CNT_W'(DEPTH))
		|=> (ovr_q == $past(ovr_q) + 1'b1) && (occ_q == CNT_W'(DEPTH)))
		else $error("push into full buffer mishandled");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && !s1_adv) |=> (pend_s1 && out_valid_q))
		else $error("read stage lost while result stalled");

endmodule

`default_nettype wire

// ===== tb/srb_ring_checker.sv =====
// Ring buffer checker: predicts each result from the accepted requests and compares it.
module srb_ring_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	srb_req_if        req,
	srb_rsp_if        rsp,
	output int        fails,
	output int        pending
);
	import srb_pkg::*;

	typedef struct {
		logic              status;
		logic [WORD_W-1:0] data;
		logic [FILL_W-1:0] fill;
		logic [OVR_W-1:0]  ovr;
	} ring_result_t;

	sample_t          ring [DEPTH];
	ptr_t             wr_ptr;
	ptr_t             rd_ptr;
	cnt_t             fill;
	logic [OVR_W-1:0] overruns;
	logic             policy;
	ring_result_t     due_results [$];
	int               errs;

	function automatic ring_result_t ring_outcome(logic [CMD_W-1:0] op,
			logic [WORD_W-1:0] word, logic [BACK_W-1:0] back);
		ring_result_t r;
		ptr_t         idx;
		r.status = STATUS_FAIL;
		r.data   = '0;
		case (op)
			CMD_PUSH: begin
				if (fill == DEPTH) begin
					overruns = overruns + 1'b1;
					if (policy == POLICY_OVERWRITE) begin
						// discard the oldest sample to make room
						rd_ptr = rd_ptr + 1'b1;
						fill   = fill - 1'b1;
					end
				end
				if (fill < DEPTH) begin
					ring[wr_ptr] = sample_t'(word);
					wr_ptr       = wr_ptr + 1'b1;
					fill         = fill + 1'b1;
					r.status     = STATUS_OK;
				end
			end
			CMD_POP: begin
				if (fill != 0) begin
					r.data   = ring[rd_ptr];
					rd_ptr   = rd_ptr + 1'b1;
					fill     = fill - 1'b1;
					r.status = STATUS_OK;
				end
			end
			CMD_PEEK: begin
				if (fill != 0 && back < fill) begin
					idx      = wr_ptr - 1'b1 - back;
					r.data   = ring[idx];
					r.status = STATUS_OK;
				end
			end
			default: begin
			end
		endcase
		r.fill = fill;
		r.ovr  = overruns;
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ring_result_t got;
		ring_result_t want;
		if (!arst_n) begin
			wr_ptr   = '0;
			rd_ptr   = '0;
			fill     = '0;
			overruns = '0;
			policy   = POLICY_DROP;
			due_results.delete();
			errs     = 0;
			fails   <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.sample_out, rsp.fill_count, rsp.overrun_total};
				if (due_results.size() == 0) begin
					$error("result transaction with nothing expected");
					errs++;
				end else begin
					want = due_results.pop_front();
					compare_field("status", 32'(want.status), 32'(got.status));
					compare_field("sample_out", want.data, got.data);
					compare_field("fill_count", 32'(want.fill), 32'(got.fill));
					compare_field("overrun_total", want.ovr, got.ovr);
				end
			end
			// a request at this edge still sees the old policy
			if (req.valid && req.ready)
				due_results.push_back(ring_outcome(req.cmd, req.sample_in, req.back_index));
			if (cfg_we)
				policy = cfg_wdata;
			fails   <= errs;
			pending <= due_results.size();
		end
	end

endmodule

// ===== tb/sample_ring_buffer_with_overrun_policy_unit_tb.sv =====
// Testbench top for the sample ring buffer: clock, reset, stimulus and verdict.
module sample_ring_buffer_with_overrun_policy_unit_tb;

	import srb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int LONG_HOLD_CYCLES = 60;
	localparam int PHASES           = 8;
	localparam int PHASE_ITEMS      = 130;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic long_hold;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   fails;
	int   pending;

	srb_req_if req_ch ();
	srb_rsp_if rsp_ch ();

	sample_ring_buffer_with_overrun_policy_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	srb_ring_checker ring_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold && !hold_done) begin
				hold_done     = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_op(logic [CMD_W-1:0] op, logic [WORD_W-1:0] word,
			logic [BACK_W-1:0] back);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= op;
		req_ch.sample_in  <= word;
		req_ch.back_index <= back;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic send_random(int push_pct);
		int                r;
		logic [CMD_W-1:0]  op;
		logic [WORD_W-1:0] word;
		logic [BACK_W-1:0] back;
		r = $urandom_range(99);
		if (r < 3)
			op = CMD_UNUSED;
		else if (r < push_pct)
			op = CMD_PUSH;
		else if (r < push_pct + (100 - push_pct) / 2)
			op = CMD_POP;
		else
			op = CMD_PEEK;
		case ($urandom_range(9))
			0: word = '0;
			1: word = '1;
			default: word = $urandom;
		endcase
		// favor recent samples, still reach the deepest ones
		back = $urandom_range(1) ? BACK_W'($urandom_range(3)) : BACK_W'($urandom_range(15));
		send_op(op, word, back);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_policy(logic p);
		cfg_we    <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("sample_ring_buffer_with_overrun_policy_unit_tb: done, errors");
		$finish;
	end

	initial begin
		int push_pct;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= 1'b0;
		long_hold         <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.cmd        <= CMD_PUSH;
		req_ch.sample_in  <= '0;
		req_ch.back_index <= '0;
		send_idle_pct      = 0;
		recv_stall_pct    <= 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty buffer, unused command, field extremes, fill up, drop when full
		send_op(CMD_POP, '0, '0);
		send_op(CMD_PEEK, '0, '0);
		send_op(CMD_UNUSED, '1, '1);
		send_op(CMD_PUSH, '0, '0);
		send_op(CMD_PUSH, '1, '1);
		send_op(CMD_PEEK, '0, 4'd0);
		send_op(CMD_PEEK, '0, 4'd1);
		send_op(CMD_PEEK, '0, 4'd2);
		for (int i = 0; i < DEPTH - 2; i++)
			send_op(CMD_PUSH, $urandom, '0);
		send_op(CMD_PUSH, 32'hA5A5_5A5A, '0);
		wait_drained();

		// overwrite when full, then reach the oldest sample
		set_policy(POLICY_OVERWRITE);
		send_op(CMD_PUSH, $urandom, '0);
		send_op(CMD_PEEK, '0, '1);
		send_op(CMD_POP, '0, '0);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			set_policy((p % 2) ? POLICY_OVERWRITE : POLICY_DROP);
			case (p % 4)
				0: begin
					send_idle_pct   = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct   = 64;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct   = 0;
					recv_stall_pct <= 64;
				end
				default: begin
					send_idle_pct   = 15;
					recv_stall_pct <= 15;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// alternate fill, drain and balanced stretches
				case ((i / 20) % 3)
					0: push_pct = 80;
					1: push_pct = 30;
					default: push_pct = 50;
				endcase
				if (p == 0 && i == 40)
					long_hold <= 1'b1;
				if (p == 4 && i == 65)
					wait_drained();
				send_random(push_pct);
			end
		end

		wait_drained();
		if (fails == 0)
			$display("sample_ring_buffer_with_overrun_policy_unit_tb: done, clean");
		else
			$display("sample_ring_buffer_with_overrun_policy_unit_tb: done, errors");
		$finish;
	end

endmodule
